// File: src/fspc_pkg.sv
// Shared types, constants and tables for the frustum sphere/point cull block.
`timescale 1ns / 1ps

package fspc_pkg;

    // Configuration port
    localparam int CFG_REGS   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ENTRY_W    = 16;     // Q3.12 matrix entry
    localparam int COEFS      = 4;      // a, b, c, w per plane
    localparam int COEF_IDX_W = 2;
    localparam int BUILT_PLANES = 6;
    localparam int PLANE_IDX_W  = 3;

    // Stream fields
    localparam int COORD_W   = 24;      // Q15.8 coordinate
    localparam int RADIUS_W  = 23;      // unsigned Q15.8
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 8;

    // Plane derivation datapath widths
    localparam int VAL_W      = 17;     // unnormalized coefficient, Q4.12
    localparam int SUM_W      = 34;     // sum of three squares
    localparam int ROOT_N_W   = 50;     // radicand, sum shifted up by 16
    localparam int ROOT_W     = 25;     // normal length in units of 2^-20
    localparam int ROOT_TOP   = 48;     // first trial bit of the square root
    localparam int NUM_W      = 42;     // dividend: mag * 2^24 + len
    localparam int DSH_W      = 43;     // divisor aligned for the top quotient bit
    localparam int OVF_W      = 44;     // divisor aligned past the quotient range
    localparam int COEF_W     = 18;     // Q2.15 normalized coefficient
    localparam int DIV_STEPS  = 18;
    localparam int DIV_CNT_W  = 5;

    // Distance datapath widths
    localparam int PROD_W = 42;
    localparam int DIST_W = 44;
    localparam int MARG_W = 45;

    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic  degen;
        coef_t a;
        coef_t b;
        coef_t c;
        coef_t w;
    } plane_t;

    localparam plane_t PLANE_RESET = '{degen: 1'b1, a: '0, b: '0, c: '0, w: '0};

    localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [COEF_W-1:0] Q_NEG_LIM = {1'b1, {(COEF_W-1){1'b0}}};

    localparam logic [COEF_IDX_W-1:0] COEF_LAST   = COEF_IDX_W'(COEFS - 1);
    localparam logic [COEF_IDX_W-1:0] NORMAL_LAST = COEF_IDX_W'(2);

    // Per plane: which matrix row combines with row 3, and whether it is subtracted
    localparam logic [1:0] PLANE_ROW [BUILT_PLANES] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic       PLANE_SUB [BUILT_PLANES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = CFG_IDX_W'(CFG_REGS - 1);

    typedef enum logic [3:0] {
        DRV_IDLE,
        DRV_LOAD,
        DRV_SUMSQ,
        DRV_CHECK,
        DRV_ROOT,
        DRV_OVF,
        DRV_DIV,
        DRV_SAT,
        DRV_STORE
    } drv_state_t;

endpackage

// File: src/fspc_plane_deriv.sv
// Sequential plane extraction: sum of squares, square root, division, and plane storage.
`timescale 1ns / 1ps

module fspc_plane_deriv #(
    parameter int PLANES = 6
) (
    input  logic                                                    aclk,
    input  logic                                                    aresetn,
    input  logic                                                    restart,
    input  logic [fspc_pkg::CFG_REGS-1:0][fspc_pkg::CFG_DATA_W-1:0] matrix,
    output logic                                                    busy,
    output fspc_pkg::plane_t [PLANES-1:0]                           planes
);
    import fspc_pkg::*;

    localparam int PIDX_W = (PLANES > 1) ? $clog2(PLANES) : 1;

    drv_state_t state_reg, state_next;

    logic [PIDX_W-1:0]     plane_reg;
    logic [COEF_IDX_W-1:0] coef_reg;
    logic [DIV_CNT_W-1:0]  iter_reg;
    val_t                  v_reg [COEFS];
    logic [SUM_W-1:0]      ssum_reg;
    logic [ROOT_N_W-1:0]   rt_n_reg;
    logic [ROOT_N_W-1:0]   rt_res_reg;
    logic [ROOT_N_W-1:0]   rt_bit_reg;
    logic                  degen_reg;
    logic [NUM_W-1:0]      rem_reg;
    logic [DSH_W-1:0]      dsh_reg;
    logic [COEF_W-1:0]     q_reg;
    logic                  ovf_reg;
    coef_t                 qc_reg [COEFS];
    plane_t [PLANES-1:0]   planes_reg;

    logic ld_en, sq_en, chk_en, rt_en, ovf_en, div_en, sat_en, st_en;
    logic plane_last;

    logic [1:0]              row_sel;
    logic                    row_sub;
    logic signed [ENTRY_W-1:0] e3_w [COEFS];
    logic signed [ENTRY_W-1:0] er_w [COEFS];
    val_t                    v_load [COEFS];
    val_t                    v_sel;
    logic signed [SUM_W-1:0] sq_w;
    logic [ROOT_N_W-1:0]     rt_try;
    logic                    rt_ge;
    logic [ROOT_W-1:0]       len_w;
    logic [VAL_W-1:0]        mag_w;
    logic [NUM_W-1:0]        num_w;
    logic [ROOT_W:0]         dbl_w;
    logic                    ovf_w;
    logic                    div_ge;
    logic [DSH_W-1:0]        div_diff;
    coef_t                   sat_w;

    assign plane_last = (plane_reg == PIDX_W'(PLANES - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DRV_IDLE:  state_next = DRV_IDLE;
            DRV_LOAD:  state_next = DRV_SUMSQ;
            DRV_SUMSQ: state_next = (coef_reg == NORMAL_LAST) ? DRV_CHECK : DRV_SUMSQ;
            DRV_CHECK: state_next = (ssum_reg == '0) ? DRV_STORE : DRV_ROOT;
            DRV_ROOT:  state_next = rt_bit_reg[0] ? DRV_OVF : DRV_ROOT;
            DRV_OVF:   state_next = DRV_DIV;
            DRV_DIV:   state_next = (iter_reg == DIV_CNT_W'(DIV_STEPS - 1)) ? DRV_SAT : DRV_DIV;
            DRV_SAT:   state_next = (coef_reg == COEF_LAST) ? DRV_STORE : DRV_OVF;
            DRV_STORE: state_next = plane_last ? DRV_IDLE : DRV_LOAD;
            default:   state_next = DRV_IDLE;
        endcase
        // A register write starts the extraction over from the first plane
        if (restart) begin
            state_next = DRV_LOAD;
        end
    end

    // Step enables
    always_comb begin
        ld_en  = 1'b0;
        sq_en  = 1'b0;
        chk_en = 1'b0;
        rt_en  = 1'b0;
        ovf_en = 1'b0;
        div_en = 1'b0;
        sat_en = 1'b0;
        st_en  = 1'b0;
        case (state_reg)
            DRV_LOAD:  ld_en  = 1'b1;
            DRV_SUMSQ: sq_en  = 1'b1;
            DRV_CHECK: chk_en = 1'b1;
            DRV_ROOT:  rt_en  = 1'b1;
            DRV_OVF:   ovf_en = 1'b1;
            DRV_DIV:   div_en = 1'b1;
            DRV_SAT:   sat_en = 1'b1;
            DRV_STORE: st_en  = 1'b1;
            default:   ;
        endcase
    end

    assign busy   = (state_reg != DRV_IDLE);
    assign planes = planes_reg;

    // Unnormalized plane: row 3 plus or minus the selected row
    assign row_sel = PLANE_ROW[PLANE_IDX_W'(plane_reg)];
    assign row_sub = PLANE_SUB[PLANE_IDX_W'(plane_reg)];

    always_comb begin
        for (int c = 0; c < COEFS; c++) begin
            e3_w[c] = signed'(matrix[3][c*ENTRY_W +: ENTRY_W]);
            er_w[c] = signed'(matrix[row_sel][c*ENTRY_W +: ENTRY_W]);
            v_load[c] = row_sub ? (VAL_W'(e3_w[c]) - VAL_W'(er_w[c]))
                                : (VAL_W'(e3_w[c]) + VAL_W'(er_w[c]));
        end
    end

    // One square per cycle
    assign v_sel = v_reg[coef_reg];
    assign sq_w  = SUM_W'(v_sel) * SUM_W'(v_sel);

    // One root bit per cycle
    assign rt_try = rt_res_reg + rt_bit_reg;
    assign rt_ge  = (rt_n_reg >= rt_try);
    assign len_w  = rt_res_reg[ROOT_W-1:0];

    // Division setup: round to nearest by dividing (mag * 2^24 + len) by 2 * len
    assign mag_w = v_sel[VAL_W-1] ? VAL_W'(-v_sel) : VAL_W'(v_sel);
    assign num_w = NUM_W'({mag_w, 24'b0}) + NUM_W'(len_w);
    assign dbl_w = {len_w, 1'b0};
    assign ovf_w = (OVF_W'(num_w) >= {dbl_w, 18'b0});

    // One quotient bit per cycle
    assign div_ge   = (DSH_W'(rem_reg) >= dsh_reg);
    assign div_diff = DSH_W'(rem_reg) - dsh_reg;

    // Apply sign and saturate to Q2.15
    always_comb begin
        if (v_sel[VAL_W-1]) begin
            sat_w = (ovf_reg || (q_reg > Q_NEG_LIM)) ? COEF_MIN : (COEF_W'(0) - q_reg);
        end else begin
            sat_w = (ovf_reg || q_reg[COEF_W-1]) ? COEF_MAX : q_reg;
        end
    end

    // Control state and plane storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= DRV_IDLE;
            plane_reg  <= '0;
            planes_reg <= {PLANES{PLANE_RESET}};
        end else begin
            state_reg <= state_next;
            if (restart) begin
                plane_reg <= '0;
            end else if (st_en && !plane_last) begin
                plane_reg <= plane_reg + PIDX_W'(1);
            end
            if (st_en) begin
                if (degen_reg) begin
                    planes_reg[plane_reg] <= PLANE_RESET;
                end else begin
                    planes_reg[plane_reg] <= '{degen: 1'b0, a: qc_reg[0], b: qc_reg[1],
                                               c: qc_reg[2], w: qc_reg[3]};
                end
            end
        end
    end

    // Arithmetic registers
    always_ff @(posedge aclk) begin
        if (ld_en) begin
            v_reg    <= v_load;
            coef_reg <= '0;
            ssum_reg <= '0;
        end
        if (sq_en) begin
            ssum_reg <= ssum_reg + $unsigned(sq_w);
            coef_reg <= coef_reg + COEF_IDX_W'(1);
        end
        if (chk_en) begin
            rt_n_reg   <= {ssum_reg, 16'b0};
            rt_res_reg <= '0;
            rt_bit_reg <= ROOT_N_W'(1) << ROOT_TOP;
            degen_reg  <= (ssum_reg == '0);
            coef_reg   <= '0;
        end
        if (rt_en) begin
            if (rt_ge) begin
                rt_n_reg   <= rt_n_reg - rt_try;
                rt_res_reg <= (rt_res_reg >> 1) + rt_bit_reg;
            end else begin
                rt_res_reg <= rt_res_reg >> 1;
            end
            rt_bit_reg <= rt_bit_reg >> 2;
        end
        if (ovf_en) begin
            rem_reg  <= num_w;
            dsh_reg  <= {dbl_w, 17'b0};
            q_reg    <= '0;
            ovf_reg  <= ovf_w;
            iter_reg <= '0;
        end
        if (div_en) begin
            if (div_ge) begin
                rem_reg <= div_diff[NUM_W-1:0];
            end
            dsh_reg  <= dsh_reg >> 1;
            q_reg    <= {q_reg[COEF_W-2:0], div_ge};
            iter_reg <= iter_reg + DIV_CNT_W'(1);
        end
        if (sat_en) begin
            qc_reg[coef_reg] <= sat_w;
            coef_reg         <= coef_reg + COEF_IDX_W'(1);
        end
    end

endmodule

// File: src/fspc_plane_test.sv
// One plane lane: signed distance of a point to a plane and the reject decision.
`timescale 1ns / 1ps

module fspc_plane_test (
    input  fspc_pkg::plane_t                       plane,
    input  logic                                   sphere,
    input  logic signed [fspc_pkg::COORD_W-1:0]    point_x,
    input  logic signed [fspc_pkg::COORD_W-1:0]    point_y,
    input  logic signed [fspc_pkg::COORD_W-1:0]    point_z,
    input  logic        [fspc_pkg::RADIUS_W-1:0]   sphere_radius,
    output logic                                   reject
);
    import fspc_pkg::*;

    logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
    logic signed [DIST_W-1:0] plane_dist;
    logic signed [MARG_W-1:0] margin;

    // Distance in Q.23; the sum cannot leave 44 bits, so no saturation is needed
    assign prod_x = PROD_W'(point_x) * PROD_W'($signed(plane.a));
    assign prod_y = PROD_W'(point_y) * PROD_W'($signed(plane.b));
    assign prod_z = PROD_W'(point_z) * PROD_W'($signed(plane.c));
    assign plane_dist = DIST_W'(prod_x) + DIST_W'(prod_y) + DIST_W'(prod_z)
                      + (DIST_W'($signed(plane.w)) <<< 8);

    // Sphere fails when the distance is below minus the radius
    assign margin = MARG_W'(plane_dist) + MARG_W'($signed({1'b0, sphere_radius, 15'b0}));

    always_comb begin
        if (plane.degen) begin
            reject = 1'b0;
        end else if (sphere) begin
            reject = margin[MARG_W-1];
        end else begin
            reject = plane_dist[DIST_W-1] || (plane_dist == '0);
        end
    end

endmodule

// File: src/frustum_sphere_point_cull.sv
// Top level of the frustum cull: config registers, input and result registers, plane lanes.
//
// Usage:
//   Write the four rows of the view-projection matrix through cfg_wr_en, cfg_index and
//   cfg_wdata (index 0..3; higher indexes are ignored). Each write starts plane
//   extraction: one plane at a time, a sum of squares over the three normal terms, a
//   25-step square root and four 18-step divisions (a plane with a zero-length normal
//   skips the root and divisions); s_tready stays low until the pass finishes.
//   Items enter on the s_ channel (tuser = sphere test flag, tdata = x, y, z, radius) and
//   one inside flag per item leaves on the m_ channel.
//   An item passes from the input register to the result register, which drives m_tdata.
//   Throughput is one item per cycle while m_tready is high and no pass runs: all planes
//   are tested in parallel lanes between the input register and the result register.
//   When the receiver stalls, the result register holds and the input register takes
//   one more item; after that s_tready falls until m_tready returns.
//   Reset clears the matrix to zero, which leaves every plane marked as never rejecting,
//   so the block is ready right after reset without an extraction pass.
`timescale 1ns / 1ps

module frustum_sphere_point_cull #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration
    input  logic                                cfg_wr_en,
    input  logic [fspc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fspc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fspc_pkg::S_TDATA_W-1:0]      s_tdata,   // point_x, point_y, point_z,
                                                           // sphere_radius, zero pad
    input  logic                                s_tuser,   // operation
    // Results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fspc_pkg::M_TDATA_W-1:0]      m_tdata    // inside_res, zero pad
);
    import fspc_pkg::*;

    localparam int LANES = (PLANE_COUNT < BUILT_PLANES) ? PLANE_COUNT : BUILT_PLANES;

    logic [CFG_REGS-1:0][CFG_DATA_W-1:0] matrix_reg;
    logic                                cfg_hit;
    logic                                deriv_busy;
    plane_t [LANES-1:0]                  planes;

    logic                       a_valid_reg;
    logic                       a_sphere_reg;
    logic signed [COORD_W-1:0]  a_x_reg, a_y_reg, a_z_reg;
    logic [RADIUS_W-1:0]        a_r_reg;
    logic                       out_valid_reg;
    logic                       inside_reg;

    logic             out_free;
    logic             a_load;
    logic             a_adv;
    logic [LANES-1:0] lane_reject;

    // Matrix registers
    assign cfg_hit = cfg_wr_en && (cfg_index <= CFG_IDX_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_reg <= '0;
        end else if (cfg_hit) begin
            matrix_reg[cfg_index[1:0]] <= cfg_wdata;
        end
    end

    fspc_plane_deriv #(
        .PLANES (LANES)
    ) u_deriv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_hit),
        .matrix  (matrix_reg),
        .busy    (deriv_busy),
        .planes  (planes)
    );

    // Handshake: input register refills when it empties or moves on and no pass is running
    assign out_free = !out_valid_reg || m_tready;
    assign a_adv    = a_valid_reg && out_free;
    assign s_tready = (!a_valid_reg || out_free) && !deriv_busy && !cfg_wr_en;
    assign a_load   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (a_load) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the item and the decision
    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_sphere_reg <= s_tuser;
            a_x_reg      <= s_tdata[COORD_W-1:0];
            a_y_reg      <= s_tdata[2*COORD_W-1:COORD_W];
            a_z_reg      <= s_tdata[3*COORD_W-1:2*COORD_W];
            a_r_reg      <= s_tdata[3*COORD_W+RADIUS_W-1:3*COORD_W];
        end
        if (a_adv) begin
            inside_reg <= ~|lane_reject;
        end
    end

    // One lane per existing plane; planes past the sixth never reject
    for (genvar p = 0; p < LANES; p++) begin : g_lane
        fspc_plane_test u_test (
            .plane         (planes[p]),
            .sphere        (a_sphere_reg),
            .point_x       (a_x_reg),
            .point_y       (a_y_reg),
            .point_z       (a_z_reg),
            .sphere_radius (a_r_reg),
            .reject        (lane_reject[p])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, inside_reg};

    // No item is taken while planes are being rebuilt
    assert property (@(posedge aclk) disable iff (!aresetn) deriv_busy |-> !s_tready)
        else $error("input taken during plane extraction");

    // An accepted register write always starts an extraction pass
    assert property (@(posedge aclk) disable iff (!aresetn) cfg_hit |=> deriv_busy)
        else $error("register write did not start extraction");

    // A held item moves into a free result register on the next edge
    assert property (@(posedge aclk) disable iff (!aresetn) a_adv |=> out_valid_reg)
        else $error("item lost between input and result register");

    // The input register is never overwritten while its item is still stuck
    assert property (@(posedge aclk) disable iff (!aresetn)
                     (a_valid_reg && !out_free) |-> !a_load)
        else $error("input register overwritten while stalled");

endmodule
